// ===== sv/oae_pkg.sv =====
// Shared types, sizes and codes of the ordered array engine.
package oae_pkg;

    // array geometry
    localparam int DEPTH     = 16;
    localparam int WORD_BITS = 32;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int LEN_W     = $clog2(DEPTH + 1);

    // stream field widths
    localparam int FUNC_W     = 3;
    localparam int VAL_W      = 32;
    localparam int POS_W      = 5;
    localparam int STATUS_W   = 2;
    localparam int EIDX_W     = 4;
    localparam int LENF_W     = 5;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 48;
    localparam int M_TUSER_W  = 3;

    typedef logic [WORD_BITS-1:0] word_t;

    // operation codes on func
    localparam logic [FUNC_W-1:0] FN_APPEND     = 3'd0;
    localparam logic [FUNC_W-1:0] FN_PREPEND    = 3'd1;
    localparam logic [FUNC_W-1:0] FN_INSERT     = 3'd2;
    localparam logic [FUNC_W-1:0] FN_FIND       = 3'd3;
    localparam logic [FUNC_W-1:0] FN_WRITE      = 3'd4;
    localparam logic [FUNC_W-1:0] FN_REMOVE     = 3'd5;
    localparam logic [FUNC_W-1:0] FN_REMOVE_VAL = 3'd6;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    // what each cell does in a cycle
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_WRITE,
        CELL_REMOVE,
        CELL_ROTATE
    } cell_op_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        cell_op_t           op;
        logic [LEN_W-1:0]   pos;
        logic [LEN_W-1:0]   tail;
        logic               keep;
        word_t              value;
    } cell_ctrl_t;

    // convert the stream value to a stored word; both are 32 bits wide
    function automatic word_t to_word(input logic signed [VAL_W-1:0] v);
        return word_t'(v);
    endfunction

    // stored word back to the 32-bit result field
    function automatic logic [VAL_W-1:0] from_word(input word_t w);
        return VAL_W'(w);
    endfunction

endpackage

// ===== sv/oae_cell.sv =====
// One array cell: holds a word and takes it from a neighbor, the head or the operand.
module oae_cell (
    input  logic                      aclk,
    input  oae_pkg::cell_ctrl_t       ctrl,
    input  logic [oae_pkg::LEN_W-1:0] cell_index,
    input  oae_pkg::word_t            left_word,
    input  oae_pkg::word_t            right_word,
    input  oae_pkg::word_t            head_word,
    output oae_pkg::word_t            word_q
);

    oae_pkg::word_t word_reg;
    oae_pkg::word_t word_next;

    // select the next word for this position
    always_comb begin
        word_next = word_reg;
        case (ctrl.op)
            oae_pkg::CELL_INSERT: begin
                if (cell_index > ctrl.pos) begin
                    word_next = left_word;
                end else if (cell_index == ctrl.pos) begin
                    word_next = ctrl.value;
                end
            end
            oae_pkg::CELL_WRITE: begin
                if (cell_index == ctrl.pos) begin
                    word_next = ctrl.value;
                end
            end
            oae_pkg::CELL_REMOVE: begin
                if (cell_index >= ctrl.pos) begin
                    word_next = right_word;
                end
            end
            oae_pkg::CELL_ROTATE: begin
                if (ctrl.keep && cell_index == ctrl.tail) begin
                    word_next = head_word;
                end else begin
                    word_next = right_word;
                end
            end
            default: begin
                word_next = word_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    assign word_q = word_reg;

endmodule

// ===== sv/oae_ctrl.sv =====
// Sequencer: decodes operations, drives the cell row and builds result beats.
module oae_ctrl (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [oae_pkg::FUNC_W-1:0]   in_func,
    input  logic [oae_pkg::VAL_W-1:0]    in_value,
    input  logic [oae_pkg::POS_W-1:0]    in_pos,
    input  oae_pkg::word_t               head_word,
    output oae_pkg::cell_ctrl_t          cell_ctrl,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [oae_pkg::STATUS_W-1:0] out_status,
    output logic                         out_has,
    output logic [oae_pkg::VAL_W-1:0]    out_value,
    output logic [oae_pkg::EIDX_W-1:0]   out_index,
    output logic [oae_pkg::EIDX_W-1:0]   out_found,
    output logic [oae_pkg::LENF_W-1:0]   out_length,
    output logic                         out_last
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_COMPACT,
        S_EMIT,
        S_SINGLE
    } state_t;

    localparam logic [oae_pkg::LEN_W-1:0] FULL_COUNT = oae_pkg::LEN_W'(oae_pkg::DEPTH);
    localparam logic [oae_pkg::LEN_W-1:0] ONE_LEN    = oae_pkg::LEN_W'(1);
    localparam logic [oae_pkg::IDX_W-1:0] ONE_IDX    = oae_pkg::IDX_W'(1);

    state_t                        state_reg,  state_next;
    logic [oae_pkg::LEN_W-1:0]     count_reg,  count_next;
    logic [oae_pkg::LEN_W-1:0]     steps_reg,  steps_next;
    logic [oae_pkg::IDX_W-1:0]     idx_reg,    idx_next;
    logic [oae_pkg::IDX_W-1:0]     found_reg,  found_next;
    logic                          hit_reg,    hit_next;
    logic [oae_pkg::STATUS_W-1:0]  sts_reg,    sts_next;
    oae_pkg::word_t                value_reg,  value_next;

    logic                          m_valid_reg,  m_valid_next;
    logic [oae_pkg::STATUS_W-1:0]  o_status_reg, o_status_next;
    logic                          o_has_reg,    o_has_next;
    logic [oae_pkg::VAL_W-1:0]     o_value_reg,  o_value_next;
    logic [oae_pkg::EIDX_W-1:0]    o_index_reg,  o_index_next;
    logic [oae_pkg::EIDX_W-1:0]    o_found_reg,  o_found_next;
    logic [oae_pkg::LENF_W-1:0]    o_length_reg, o_length_next;
    logic                          o_last_reg,   o_last_next;

    logic                          out_free;
    logic                          head_match;
    logic                          emit_last;
    logic [oae_pkg::LEN_W-1:0]     count_less;
    oae_pkg::word_t                in_word;
    oae_pkg::cell_ctrl_t           cc;

    assign out_free   = !m_valid_reg || m_ready;
    assign head_match = (head_word == value_reg);
    assign count_less = count_reg - ONE_LEN;
    assign emit_last  = (oae_pkg::LEN_W'(idx_reg) == count_less);
    assign in_word    = oae_pkg::to_word(in_value);
    assign s_ready    = (state_reg == S_IDLE);

    // next-state and cell command
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        steps_next    = steps_reg;
        idx_next      = idx_reg;
        found_next    = found_reg;
        hit_next      = hit_reg;
        sts_next      = sts_reg;
        value_next    = value_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        o_status_next = o_status_reg;
        o_has_next    = o_has_reg;
        o_value_next  = o_value_reg;
        o_index_next  = o_index_reg;
        o_found_next  = o_found_reg;
        o_length_next = o_length_reg;
        o_last_next   = o_last_reg;
        cc            = '0;
        cc.op         = oae_pkg::CELL_HOLD;
        cc.tail       = count_less;
        cc.keep       = 1'b1;
        cc.value      = in_word;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    value_next = in_word;
                    idx_next   = '0;
                    found_next = '0;
                    hit_next   = 1'b0;
                    steps_next = count_reg;
                    sts_next   = oae_pkg::ST_OK;
                    case (in_func)
                        oae_pkg::FN_APPEND, oae_pkg::FN_PREPEND, oae_pkg::FN_INSERT: begin
                            if (count_reg == FULL_COUNT) begin
                                sts_next   = oae_pkg::ST_FULL;
                                state_next = S_SINGLE;
                            end else if (in_func == oae_pkg::FN_INSERT &&
                                         int'(in_pos) > int'(count_reg)) begin
                                sts_next   = oae_pkg::ST_RANGE;
                                state_next = S_SINGLE;
                            end else begin
                                cc.op = oae_pkg::CELL_INSERT;
                                if (in_func == oae_pkg::FN_APPEND) begin
                                    cc.pos = count_reg;
                                end else if (in_func == oae_pkg::FN_PREPEND) begin
                                    cc.pos = '0;
                                end else begin
                                    cc.pos = oae_pkg::LEN_W'(in_pos);
                                end
                                count_next = count_reg + ONE_LEN;
                                state_next = S_EMIT;
                            end
                        end
                        oae_pkg::FN_FIND: begin
                            if (count_reg == '0) begin
                                sts_next   = oae_pkg::ST_NOT_FOUND;
                                state_next = S_SINGLE;
                            end else begin
                                state_next = S_SCAN;
                            end
                        end
                        oae_pkg::FN_WRITE: begin
                            if (int'(in_pos) >= int'(count_reg)) begin
                                sts_next   = oae_pkg::ST_RANGE;
                                state_next = S_SINGLE;
                            end else begin
                                cc.op      = oae_pkg::CELL_WRITE;
                                cc.pos     = oae_pkg::LEN_W'(in_pos);
                                state_next = S_EMIT;
                            end
                        end
                        oae_pkg::FN_REMOVE: begin
                            if (int'(in_pos) >= int'(count_reg)) begin
                                sts_next   = oae_pkg::ST_RANGE;
                                state_next = S_SINGLE;
                            end else begin
                                cc.op      = oae_pkg::CELL_REMOVE;
                                cc.pos     = oae_pkg::LEN_W'(in_pos);
                                count_next = count_less;
                                state_next = (count_less == '0) ? S_SINGLE : S_EMIT;
                            end
                        end
                        oae_pkg::FN_REMOVE_VAL: begin
                            state_next = (count_reg == '0) ? S_SINGLE : S_COMPACT;
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // rotate the whole row once past the head, note the last match
            S_SCAN: begin
                cc.op      = oae_pkg::CELL_ROTATE;
                hit_next   = hit_reg || head_match;
                found_next = head_match ? idx_reg : found_reg;
                idx_next   = idx_reg + ONE_IDX;
                steps_next = steps_reg - ONE_LEN;
                if (steps_reg == ONE_LEN) begin
                    sts_next   = (hit_reg || head_match) ? oae_pkg::ST_OK
                                                         : oae_pkg::ST_NOT_FOUND;
                    state_next = S_SINGLE;
                end
            end

            // pop the head each cycle, push it back at the tail unless it matches
            S_COMPACT: begin
                cc.op      = oae_pkg::CELL_ROTATE;
                cc.keep    = !head_match;
                steps_next = steps_reg - ONE_LEN;
                if (head_match) begin
                    count_next = count_less;
                end
                if (steps_reg == ONE_LEN) begin
                    idx_next = '0;
                    if (head_match && count_less == '0) begin
                        state_next = S_SINGLE;
                    end else begin
                        state_next = S_EMIT;
                    end
                end
            end

            // one beat per element, row rotates so the next element is at the head
            S_EMIT: begin
                if (out_free) begin
                    cc.op         = oae_pkg::CELL_ROTATE;
                    m_valid_next  = 1'b1;
                    o_status_next = oae_pkg::ST_OK;
                    o_has_next    = 1'b1;
                    o_value_next  = oae_pkg::from_word(head_word);
                    o_index_next  = oae_pkg::EIDX_W'(idx_reg);
                    o_found_next  = '0;
                    o_length_next = oae_pkg::LENF_W'(count_reg);
                    o_last_next   = emit_last;
                    idx_next      = idx_reg + ONE_IDX;
                    if (emit_last) begin
                        state_next = S_IDLE;
                    end
                end
            end

            // single beat: errors, find answer, empty array
            S_SINGLE: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    o_status_next = sts_reg;
                    o_has_next    = 1'b0;
                    o_value_next  = '0;
                    o_index_next  = '0;
                    o_found_next  = oae_pkg::EIDX_W'(found_reg);
                    o_length_next = oae_pkg::LENF_W'(count_reg);
                    o_last_next   = 1'b1;
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        steps_reg    <= steps_next;
        idx_reg      <= idx_next;
        found_reg    <= found_next;
        hit_reg      <= hit_next;
        sts_reg      <= sts_next;
        value_reg    <= value_next;
        o_status_reg <= o_status_next;
        o_has_reg    <= o_has_next;
        o_value_reg  <= o_value_next;
        o_index_reg  <= o_index_next;
        o_found_reg  <= o_found_next;
        o_length_reg <= o_length_next;
        o_last_reg   <= o_last_next;
    end

    assign cell_ctrl  = cc;
    assign m_valid    = m_valid_reg;
    assign out_status = o_status_reg;
    assign out_has    = o_has_reg;
    assign out_value  = o_value_reg;
    assign out_index  = o_index_reg;
    assign out_found  = o_found_reg;
    assign out_length = o_length_reg;
    assign out_last   = o_last_reg;

    // length never passes the row size
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_COUNT)
        else $error("word count beyond depth");

    // the beat that ends a run returns the sequencer to idle
    a_emit_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EMIT && out_free && emit_last) |=> state_reg == S_IDLE)
        else $error("run did not end after last element");

    // a beat without an element always closes its run
    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !o_has_reg) |-> o_last_reg)
        else $error("elementless beat not marked last");

    // sweeps always have work left
    a_steps_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN || state_reg == S_COMPACT) |-> steps_reg != '0)
        else $error("sweep with no steps left");

endmodule

// ===== sv/ordered_array_engine_core.sv =====
// Top level of the ordered array engine: stream ports, cell row and sequencer.
// The array lives in a row of DEPTH cells, one word each; insert, overwrite and
// remove at a position move the whole row as the item is accepted, and results
// leave by rotating the row one word per cycle past cell 0 while the consumer is
// ready. An append, prepend, insert, overwrite or remove at a position moves the
// row, then emits the array; a find makes one sweep, then the answer beat; a
// remove-value makes one sweep to compact, one to emit; an error or empty-array
// answer is a single beat. s_tready is high only between items. Stored words come
// up undefined after reset, but only words below the length are read.
module ordered_array_engine_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // func[2:0], value[34:3], position[39:35]
    input  logic [oae_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // element_value[31:0], element_index[35:32], found_index[39:36], length[44:40]
    output logic [oae_pkg::M_TDATA_W-1:0] m_tdata,
    // status[1:0], has_element[2]
    output logic [oae_pkg::M_TUSER_W-1:0] m_tuser,
    output logic                          m_tlast
);

    oae_pkg::cell_ctrl_t            cell_ctrl;
    oae_pkg::word_t                 row_word [oae_pkg::DEPTH];
    logic [oae_pkg::STATUS_W-1:0]   out_status;
    logic                           out_has;
    logic [oae_pkg::VAL_W-1:0]      out_value;
    logic [oae_pkg::EIDX_W-1:0]     out_index;
    logic [oae_pkg::EIDX_W-1:0]     out_found;
    logic [oae_pkg::LENF_W-1:0]     out_length;

    // sequencer
    oae_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .in_func    (s_tdata[2:0]),
        .in_value   (s_tdata[34:3]),
        .in_pos     (s_tdata[39:35]),
        .head_word  (row_word[0]),
        .cell_ctrl  (cell_ctrl),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .out_status (out_status),
        .out_has    (out_has),
        .out_value  (out_value),
        .out_index  (out_index),
        .out_found  (out_found),
        .out_length (out_length),
        .out_last   (m_tlast)
    );

    // row of cells, each wired to its neighbors and to the head
    for (genvar g = 0; g < oae_pkg::DEPTH; g++) begin : g_cell
        oae_pkg::word_t left_w;
        oae_pkg::word_t right_w;

        if (g == 0) begin : g_first
            assign left_w = row_word[g];
        end else begin : g_inner_l
            assign left_w = row_word[g-1];
        end

        if (g == oae_pkg::DEPTH - 1) begin : g_lastc
            assign right_w = row_word[g];
        end else begin : g_inner_r
            assign right_w = row_word[g+1];
        end

        oae_cell u_cell (
            .aclk       (aclk),
            .ctrl       (cell_ctrl),
            .cell_index (oae_pkg::LEN_W'(g)),
            .left_word  (left_w),
            .right_word (right_w),
            .head_word  (row_word[0]),
            .word_q     (row_word[g])
        );
    end

    // pack the result beat
    assign m_tdata = {3'b000, out_length, out_found, out_index, out_value};
    assign m_tuser = {out_has, out_status};

endmodule

// ===== tb/ordered_array_engine_core_tb.sv =====
// Self-checking stream testbench for the ordered array engine core.
`timescale 1ns / 100ps

module ordered_array_engine_core_tb;
    import oae_pkg::*;

    // func code with no operation behind it
    localparam logic [FUNC_W-1:0] FN_UNUSED = 3'd7;

    // one result beat as it leaves the block
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                has;
        logic [VAL_W-1:0]    value;
        logic [EIDX_W-1:0]   idx;
        logic [EIDX_W-1:0]   found;
        logic [LENF_W-1:0]   len;
        logic                last;
    } array_beat_t;

    logic                   aclk;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [M_TUSER_W-1:0]   m_tuser;
    logic                   m_tlast;

    // mirrored array contents and the beats it should produce
    logic [VAL_W-1:0]       arr_words [DEPTH];
    int                     arr_len = 0;
    array_beat_t            array_beats_q [$];

    int                     err_count  = 0;
    int                     ready_hold = 0;
    bit                     idle_off   = 1'b0;

    logic [FUNC_W-1:0]      grow_ops  [3] = '{FN_APPEND, FN_PREPEND, FN_INSERT};
    logic [FUNC_W-1:0]      other_ops [4] = '{FN_FIND, FN_WRITE, FN_REMOVE, FN_REMOVE_VAL};

    ordered_array_engine_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // mostly short gaps, a few long ones, none while idling is off
    function automatic int pick_gap();
        if (idle_off)
            return 0;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return 0;
            5, 6, 7:       return $urandom_range(1, 2);
            8:             return $urandom_range(3, 6);
            default:       return $urandom_range(10, 30);
        endcase
    endfunction

    // values that collide often, extremes, stored words, or anything
    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2, 3:    return 32'($urandom_range(0, 5)) - 32'd2;
            4, 5:    return (arr_len > 0) ? arr_words[$urandom_range(0, arr_len - 1)]
                                          : 32'($urandom);
            default: return 32'($urandom);
        endcase
    endfunction

    // mostly legal positions for the op, sometimes any 5-bit value
    function automatic logic [POS_W-1:0] pick_position(input logic [FUNC_W-1:0] fn);
        if ($urandom_range(0, 7) == 0)
            return POS_W'($urandom_range(0, 31));
        if (fn == FN_INSERT)
            return POS_W'($urandom_range(0, arr_len));
        return (arr_len > 0) ? POS_W'($urandom_range(0, arr_len - 1)) : '0;
    endfunction

    // single-beat answer: error, find, or empty array
    task automatic push_single(input logic [STATUS_W-1:0] st, input int found_at);
        array_beat_t b;
        b        = '0;
        b.status = st;
        b.found  = EIDX_W'(found_at);
        b.len    = LENF_W'(arr_len);
        b.last   = 1'b1;
        array_beats_q.push_back(b);
    endtask

    // whole array, one beat per word
    task automatic push_array();
        array_beat_t b;
        if (arr_len == 0) begin
            push_single(ST_OK, 0);
            return;
        end
        for (int k = 0; k < arr_len; k++) begin
            b        = '0;
            b.status = ST_OK;
            b.has    = 1'b1;
            b.value  = arr_words[k];
            b.idx    = EIDX_W'(k);
            b.len    = LENF_W'(arr_len);
            b.last   = (k == arr_len - 1);
            array_beats_q.push_back(b);
        end
    endtask

    // apply one op to the mirrored array and queue the beats it causes
    task automatic update_array(input logic [FUNC_W-1:0] fn, input logic [VAL_W-1:0] val,
                                input logic [POS_W-1:0] pos);
        int  at;
        int  j;
        int  found_at;
        bit  hit;
        case (fn)
            FN_APPEND, FN_PREPEND, FN_INSERT: begin
                if (arr_len >= DEPTH) begin
                    push_single(ST_FULL, 0);
                end else if (fn == FN_INSERT && pos > arr_len) begin
                    push_single(ST_RANGE, 0);
                end else begin
                    at = (fn == FN_APPEND) ? arr_len : (fn == FN_PREPEND) ? 0 : int'(pos);
                    for (int k = arr_len; k > at; k--)
                        arr_words[k] = arr_words[k - 1];
                    arr_words[at] = val;
                    arr_len++;
                    push_array();
                end
            end
            FN_FIND: begin
                hit      = 1'b0;
                found_at = 0;
                for (int k = 0; k < arr_len; k++) begin
                    if (arr_words[k] == val) begin
                        hit      = 1'b1;
                        found_at = k;
                    end
                end
                push_single(hit ? ST_OK : ST_NOT_FOUND, found_at);
            end
            FN_WRITE: begin
                if (pos >= arr_len) begin
                    push_single(ST_RANGE, 0);
                end else begin
                    arr_words[pos] = val;
                    push_array();
                end
            end
            FN_REMOVE: begin
                if (pos >= arr_len) begin
                    push_single(ST_RANGE, 0);
                end else begin
                    for (int k = int'(pos); k + 1 < arr_len; k++)
                        arr_words[k] = arr_words[k + 1];
                    arr_len--;
                    push_array();
                end
            end
            FN_REMOVE_VAL: begin
                j = 0;
                for (int k = 0; k < arr_len; k++) begin
                    if (arr_words[k] != val) begin
                        arr_words[j] = arr_words[k];
                        j++;
                    end
                end
                arr_len = j;
                push_array();
            end
            default: ;
        endcase
    endtask

    // one input beat; valid stays up when no gap follows
    task automatic send_op(input logic [FUNC_W-1:0] fn, input logic [VAL_W-1:0] val,
                           input logic [POS_W-1:0] pos);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {pos, val, fn};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        update_array(fn, val, pos);
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // compare one accepted result beat with the oldest one queued
    task automatic check_array_beat();
        array_beat_t got;
        array_beat_t want;
        got.status = m_tuser[1:0];
        got.has    = m_tuser[2];
        got.value  = m_tdata[31:0];
        got.idx    = m_tdata[35:32];
        got.found  = m_tdata[39:36];
        got.len    = m_tdata[44:40];
        got.last   = m_tlast;
        if (array_beats_q.size() == 0) begin
            if (err_count < 10)
                $display({"%0t: unexpected beat st=%0d has=%0b val=%h idx=%0d",
                          " fnd=%0d len=%0d last=%0b"},
                         $realtime, got.status, got.has, got.value, got.idx, got.found,
                         got.len, got.last);
            err_count++;
            return;
        end
        want = array_beats_q.pop_front();
        if (got.status !== want.status || got.has !== want.has || got.value !== want.value ||
            got.idx !== want.idx || got.found !== want.found || got.len !== want.len ||
            got.last !== want.last) begin
            if (err_count < 10) begin
                $display("%0t: beat mismatch", $realtime);
                $display("  exp st=%0d has=%0b val=%h idx=%0d fnd=%0d len=%0d last=%0b",
                         want.status, want.has, want.value, want.idx, want.found,
                         want.len, want.last);
                $display("  got st=%0d has=%0b val=%h idx=%0d fnd=%0d len=%0d last=%0b",
                         got.status, got.has, got.value, got.idx, got.found,
                         got.len, got.last);
            end
            err_count++;
        end
    endtask

    // result side: check accepted beats, stall at random
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready)
                check_array_beat();
            if (ready_hold > 0) begin
                m_tready <= 1'b0;
                ready_hold--;
            end else begin
                m_tready   <= 1'b1;
                ready_hold = pick_gap();
            end
        end
    end

    // empty-array answers, extremes, every op and the range and not-found errors
    task automatic test_basic_ops();
        send_op(FN_FIND,       32'd5,        5'd0);
        send_op(FN_REMOVE_VAL, 32'd5,        5'd0);
        send_op(FN_WRITE,      32'd1,        5'd0);
        send_op(FN_REMOVE,     32'd0,        5'd0);
        send_op(FN_INSERT,     32'd1,        5'd1);
        send_op(FN_APPEND,     32'h8000_0000, 5'd0);
        send_op(FN_PREPEND,    32'h7fff_ffff, 5'd0);
        send_op(FN_INSERT,     32'd7,        5'd2);
        send_op(FN_INSERT,     32'd7,        5'd1);
        send_op(FN_FIND,       32'd7,        5'd0);
        send_op(FN_FIND,       32'h7fff_ffff, 5'd0);
        send_op(FN_WRITE,      32'hffff_ffff, 5'd3);
        send_op(FN_WRITE,      32'd9,        5'd4);
        send_op(FN_REMOVE,     32'd0,        5'd4);
        send_op(FN_INSERT,     32'd9,        5'd31);
        send_op(FN_UNUSED,     32'hffff_ffff, 5'd31);
        send_op(FN_REMOVE_VAL, 32'd12345,    5'd0);
        send_op(FN_REMOVE,     32'd0,        5'd0);
        send_op(FN_APPEND,     32'd7,        5'd0);
        send_op(FN_REMOVE_VAL, 32'd7,        5'd0);
        send_op(FN_REMOVE_VAL, 32'h8000_0000, 5'd0);
        send_op(FN_REMOVE,     32'd0,        5'd0);
        send_op(FN_APPEND,     32'd0,        5'd0);
        send_op(FN_REMOVE_VAL, 32'd0,        5'd0);
    endtask

    // fill to DEPTH, then hit the full checks and work at the top index
    task automatic test_full_array();
        logic [FUNC_W-1:0] fn;
        while (arr_len < DEPTH) begin
            fn = grow_ops[$urandom_range(0, 2)];
            send_op(fn, pick_value(), pick_position(fn));
        end
        send_op(FN_APPEND,     pick_value(), 5'd0);
        send_op(FN_PREPEND,    pick_value(), 5'd0);
        send_op(FN_INSERT,     pick_value(), 5'd3);
        send_op(FN_INSERT,     pick_value(), 5'd31);
        send_op(FN_FIND,       pick_value(), 5'd0);
        send_op(FN_WRITE,      pick_value(), 5'(DEPTH - 1));
        send_op(FN_REMOVE,     pick_value(), 5'(DEPTH - 1));
        send_op(FN_INSERT,     pick_value(), 5'(DEPTH - 1));
        send_op(FN_WRITE,      pick_value(), 5'(DEPTH));
        send_op(FN_REMOVE_VAL, pick_value(), 5'd0);
    endtask

    // random ops, grow_pct sets how often a word is added
    task automatic test_random_ops(input int n_ops, input int grow_pct);
        logic [FUNC_W-1:0] fn;
        int                done;
        done = 0;
        while (done < n_ops) begin
            if ($urandom_range(0, 49) == 0) begin
                send_op(FN_UNUSED, 32'($urandom), POS_W'($urandom));
            end else begin
                if ($urandom_range(0, 99) < grow_pct)
                    fn = grow_ops[$urandom_range(0, 2)];
                else
                    fn = other_ops[$urandom_range(0, 3)];
                send_op(fn, pick_value(), pick_position(fn));
                done++;
            end
        end
    endtask

    // back-to-back stretch with both sides always ready
    task automatic test_no_idle(input int n_ops);
        idle_off = 1'b1;
        test_random_ops(n_ops, 50);
        idle_off = 1'b0;
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_basic_ops();
        test_full_array();
        test_random_ops(35, 70);
        test_random_ops(35, 25);
        test_no_idle(25);
        test_random_ops(35, 65);
        test_random_ops(30, 30);
        s_tvalid <= 1'b0;

        // drain, then allow for trailing beats
        while (array_beats_q.size() != 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);

        if (err_count == 0 && array_beats_q.size() == 0) begin
            $display("ordered_array_engine_core_tb: clean");
        end else begin
            $display("ordered_array_engine_core_tb: errors");
        end
        $finish;
    end

    // hang guard
    initial begin
        #20_000_000;
        $display("ordered_array_engine_core_tb: errors");
        $finish;
    end

endmodule
